// ===== hdl/depth_pixel_backprojection_macros.svh =====
// Assertion macros used by the checker file of the back-projection block.
`ifndef DEPTH_PIXEL_BACKPROJECTION_MACROS_SVH
`define DEPTH_PIXEL_BACKPROJECTION_MACROS_SVH

// Concurrent assertion, disabled while reset is high.
`define BPJ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds during reset.
`define BPJ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/bpj_pkg.sv =====
// Types, constants and register codes of the depth pixel back-projection block.
package bpj_pkg;

   localparam int DEPTH_W    = 16;
   localparam int COLOR_W    = 8;
   localparam int PIX_W      = 12;
   localparam int SIZE_W     = 13;
   localparam int AD_W       = 13;
   localparam int INV_W      = 24;
   localparam int RANGE_W    = 16;
   localparam int COORD_W    = 21;
   localparam int SQ_W       = 2 * COORD_W;
   localparam int DSQ_W      = 2 * DEPTH_W;
   localparam int RANGE_SQ_W = 2 * RANGE_W;
   localparam int DIST_W     = SQ_W + 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam int COORD_BITS_DEF          = 12;
   localparam int INV_FOCAL_FRAC_BITS_DEF = 24;

   localparam logic [DIST_W-1:0]  MIN_RANGE_SQ = DIST_W'(64'd2250000);
   localparam logic [COORD_W-1:0] NEG_LIMIT    = COORD_W'(64'd1048576);
   localparam logic [COORD_W-1:0] POS_LIMIT    = COORD_W'(64'd1048575);

   localparam logic [SIZE_W-1:0]  IMAGE_WIDTH_RST  = SIZE_W'(640);
   localparam logic [SIZE_W-1:0]  IMAGE_HEIGHT_RST = SIZE_W'(480);
   localparam logic [SIZE_W-1:0]  ROW_FIRST_RST    = SIZE_W'(0);
   localparam logic [SIZE_W-1:0]  ROW_END_RST      = SIZE_W'(480);
   localparam logic [INV_W-1:0]   INV_FOCAL_RST    = INV_W'(33554);
   localparam logic [RANGE_W-1:0] RANGE_MAX_RST    = RANGE_W'(50000);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_ROW_FIRST    = 3'd2,
      CSR_ROW_END      = 3'd3,
      CSR_INV_FOCAL_X  = 3'd4,
      CSR_INV_FOCAL_Y  = 3'd5,
      CSR_RANGE_MAX    = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [SIZE_W-1:0]     image_width;
      logic [SIZE_W-1:0]     image_height;
      logic [SIZE_W-1:0]     row_first;
      logic [SIZE_W-1:0]     row_end;
      logic [INV_W-1:0]      inv_focal_x;
      logic [INV_W-1:0]      inv_focal_y;
      logic [RANGE_SQ_W-1:0] range_sq;
   } cfg_type;

   typedef struct packed {
      logic [DEPTH_W-1:0] depth;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } pixel_type;

endpackage

// ===== hdl/bpj_csr.sv =====
// Configuration register file of the back-projection block.
module bpj_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [bpj_pkg::CSR_IDX_W-1:0]    wr_index,
   input  logic [bpj_pkg::CSR_DATA_W-1:0]   wr_data,
   output bpj_pkg::cfg_type                 cfg
);

   logic [bpj_pkg::SIZE_W-1:0]     image_width_ff;
   logic [bpj_pkg::SIZE_W-1:0]     image_height_ff;
   logic [bpj_pkg::SIZE_W-1:0]     row_first_ff;
   logic [bpj_pkg::SIZE_W-1:0]     row_end_ff;
   logic [bpj_pkg::INV_W-1:0]      inv_focal_x_ff;
   logic [bpj_pkg::INV_W-1:0]      inv_focal_y_ff;
   logic [bpj_pkg::RANGE_W-1:0]    range_max_ff;
   logic [bpj_pkg::RANGE_SQ_W-1:0] range_sq_ff;
   logic [bpj_pkg::RANGE_SQ_W-1:0] range_sq_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= bpj_pkg::IMAGE_WIDTH_RST;
         image_height_ff <= bpj_pkg::IMAGE_HEIGHT_RST;
         row_first_ff    <= bpj_pkg::ROW_FIRST_RST;
         row_end_ff      <= bpj_pkg::ROW_END_RST;
         inv_focal_x_ff  <= bpj_pkg::INV_FOCAL_RST;
         inv_focal_y_ff  <= bpj_pkg::INV_FOCAL_RST;
         range_max_ff    <= bpj_pkg::RANGE_MAX_RST;
      end else if (wr_en) begin
         case (bpj_pkg::csr_index_type'(wr_index))
            bpj_pkg::CSR_IMAGE_WIDTH: begin
               image_width_ff <= wr_data[bpj_pkg::SIZE_W-1:0];
            end
            bpj_pkg::CSR_IMAGE_HEIGHT: begin
               image_height_ff <= wr_data[bpj_pkg::SIZE_W-1:0];
            end
            bpj_pkg::CSR_ROW_FIRST: begin
               row_first_ff <= wr_data[bpj_pkg::SIZE_W-1:0];
            end
            bpj_pkg::CSR_ROW_END: begin
               row_end_ff <= wr_data[bpj_pkg::SIZE_W-1:0];
            end
            bpj_pkg::CSR_INV_FOCAL_X: begin
               inv_focal_x_ff <= wr_data[bpj_pkg::INV_W-1:0];
            end
            bpj_pkg::CSR_INV_FOCAL_Y: begin
               inv_focal_y_ff <= wr_data[bpj_pkg::INV_W-1:0];
            end
            bpj_pkg::CSR_RANGE_MAX: begin
               range_max_ff <= wr_data[bpj_pkg::RANGE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // squared range limit, registered from the range register
   assign range_sq_in = range_max_ff * range_max_ff;

   always_ff @(posedge clock) begin
      range_sq_ff <= range_sq_in;
   end

   assign cfg.image_width  = image_width_ff;
   assign cfg.image_height = image_height_ff;
   assign cfg.row_first    = row_first_ff;
   assign cfg.row_end      = row_end_ff;
   assign cfg.inv_focal_x  = inv_focal_x_ff;
   assign cfg.inv_focal_y  = inv_focal_y_ff;
   assign cfg.range_sq     = range_sq_ff;

endmodule

// ===== hdl/bpj_axis.sv =====
// One projection axis: two multiplies, rounding with saturation, and the square.
module bpj_axis #(
   parameter int INV_FOCAL_FRAC_BITS = bpj_pkg::INV_FOCAL_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic [bpj_pkg::DEPTH_W-1:0]         depth,
   input  logic [bpj_pkg::AD_W-1:0]            offset_mag,
   input  logic                                offset_neg,
   input  logic [bpj_pkg::INV_W-1:0]           inv_focal,
   output logic signed [bpj_pkg::COORD_W-1:0]  coord,
   output logic [bpj_pkg::SQ_W-1:0]            mag_sq
);

   localparam int SCALED_W = bpj_pkg::DEPTH_W + bpj_pkg::AD_W;
   localparam int PROD_W   = SCALED_W + bpj_pkg::INV_W;
   localparam int SUM_W    = PROD_W + 1;
   localparam int SHIFT    = INV_FOCAL_FRAC_BITS + 1;
   localparam int RND_W    = SUM_W - SHIFT;

   logic [SCALED_W-1:0]            scaled_ff;
   logic                           neg_a_ff;
   logic [PROD_W-1:0]              prod_ff;
   logic                           neg_b_ff;
   logic [bpj_pkg::COORD_W-1:0]    mag_ff;
   logic [bpj_pkg::COORD_W-1:0]    coord_c_ff;
   logic [bpj_pkg::COORD_W-1:0]    coord_ff;
   logic [bpj_pkg::SQ_W-1:0]       sq_ff;

   logic [SUM_W-1:0]               rnd_sum;
   logic [RND_W-1:0]               rnd;
   logic [bpj_pkg::COORD_W-1:0]    mag_in;
   logic [bpj_pkg::COORD_W-1:0]    coord_in;

   always_comb begin
      rnd_sum = {1'b0, prod_ff} + (SUM_W'(1) << INV_FOCAL_FRAC_BITS);
      rnd     = RND_W'(rnd_sum >> SHIFT);
      if (neg_b_ff) begin
         mag_in = (rnd > RND_W'(bpj_pkg::NEG_LIMIT)) ? bpj_pkg::NEG_LIMIT
                                                     : bpj_pkg::COORD_W'(rnd);
         coord_in = ~mag_in + bpj_pkg::COORD_W'(1);
      end else begin
         mag_in = (rnd > RND_W'(bpj_pkg::POS_LIMIT)) ? bpj_pkg::POS_LIMIT
                                                     : bpj_pkg::COORD_W'(rnd);
         coord_in = mag_in;
      end
   end

   always_ff @(posedge clock) begin
      scaled_ff  <= depth * offset_mag;
      neg_a_ff   <= offset_neg;
      prod_ff    <= scaled_ff * inv_focal;
      neg_b_ff   <= neg_a_ff;
      mag_ff     <= mag_in;
      coord_c_ff <= coord_in;
      sq_ff      <= mag_ff * mag_ff;
      coord_ff   <= coord_c_ff;
   end

   assign coord  = signed'(coord_ff);
   assign mag_sq = sq_ff;

endmodule

// ===== hdl/depth_pixel_backprojection.sv =====
// Top level of the pinhole depth pixel back-projection pipeline.
// One depth pixel is taken per clock while busy is low; busy is high only during
// reset. A pixel whose row lies in the window and whose squared range falls in
// [1500^2, range_max_mm^2] appears on the rsp_ ports, flagged by rsp_valid for
// one cycle; other pixels produce nothing. The seven-stage pipeline (offset, two
// multiplies per axis, rounding, squares, sum, range compare) never stalls, so
// rsp_ results must be captured when shown. csr_ready is always high; write
// registers only while no pixel is in flight.
module depth_pixel_backprojection #(
   parameter int COORD_BITS          = bpj_pkg::COORD_BITS_DEF,
   parameter int INV_FOCAL_FRAC_BITS = bpj_pkg::INV_FOCAL_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [bpj_pkg::DEPTH_W-1:0]         req_depth_mm,
   input  logic [bpj_pkg::COLOR_W-1:0]         req_red,
   input  logic [bpj_pkg::COLOR_W-1:0]         req_green,
   input  logic [bpj_pkg::COLOR_W-1:0]         req_blue,
   input  logic [bpj_pkg::PIX_W-1:0]           req_column,
   input  logic [bpj_pkg::PIX_W-1:0]           req_row,
   output logic                                rsp_valid,
   output logic [bpj_pkg::DEPTH_W-1:0]         rsp_pos_forward,
   output logic signed [bpj_pkg::COORD_W-1:0]  rsp_pos_left,
   output logic signed [bpj_pkg::COORD_W-1:0]  rsp_pos_up,
   output logic [bpj_pkg::COLOR_W-1:0]         rsp_out_red,
   output logic [bpj_pkg::COLOR_W-1:0]         rsp_out_green,
   output logic [bpj_pkg::COLOR_W-1:0]         rsp_out_blue,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bpj_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bpj_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int STAGES = 6;
   localparam logic [bpj_pkg::PIX_W-1:0] COORD_MASK =
      bpj_pkg::PIX_W'((64'd1 << COORD_BITS) - 64'd1);

   bpj_pkg::cfg_type   cfg;
   bpj_pkg::pixel_type pipe_ff [STAGES];
   logic               valid_ff [STAGES];

   logic                          accept;
   logic [bpj_pkg::PIX_W-1:0]     col_m;
   logic [bpj_pkg::PIX_W-1:0]     row_m;
   logic [bpj_pkg::SIZE_W-1:0]    col2;
   logic [bpj_pkg::SIZE_W-1:0]    row2;
   logic                          row_ok;
   logic                          negx_in;
   logic                          negy_in;
   logic [bpj_pkg::AD_W-1:0]      adx_in;
   logic [bpj_pkg::AD_W-1:0]      ady_in;

   logic                          negx_ff;
   logic                          negy_ff;
   logic [bpj_pkg::AD_W-1:0]      adx_ff;
   logic [bpj_pkg::AD_W-1:0]      ady_ff;

   logic signed [bpj_pkg::COORD_W-1:0] coordx;
   logic signed [bpj_pkg::COORD_W-1:0] coordy;
   logic [bpj_pkg::SQ_W-1:0]           sqx;
   logic [bpj_pkg::SQ_W-1:0]           sqy;
   logic [bpj_pkg::DSQ_W-1:0]          dsq_ff;
   logic [bpj_pkg::DIST_W-1:0]         dist_ff;
   logic signed [bpj_pkg::COORD_W-1:0] left_ff;
   logic signed [bpj_pkg::COORD_W-1:0] up_ff;
   logic                               in_range;
   logic                               rsp_valid_ff;
   bpj_pkg::pixel_type                 rsp_pix_ff;
   logic signed [bpj_pkg::COORD_W-1:0] rsp_left_ff;
   logic signed [bpj_pkg::COORD_W-1:0] rsp_up_ff;

   assign busy      = reset;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   bpj_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // stage 1: half-pixel offsets and row window
   always_comb begin
      col_m  = req_column & COORD_MASK;
      row_m  = req_row & COORD_MASK;
      col2   = {col_m, 1'b0};
      row2   = {row_m, 1'b0};
      row_ok = ({1'b0, row_m} >= cfg.row_first) && ({1'b0, row_m} < cfg.row_end);
      negx_in = col2 > cfg.image_width;
      negy_in = row2 > cfg.image_height;
      adx_in  = negx_in ? (col2 - cfg.image_width) : (cfg.image_width - col2);
      ady_in  = negy_in ? (row2 - cfg.image_height) : (cfg.image_height - row2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STAGES; i++) begin
            valid_ff[i] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff[0] <= accept && row_ok;
         for (int i = 1; i < STAGES; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
         rsp_valid_ff <= valid_ff[STAGES-1] && in_range;
      end
   end

   always_ff @(posedge clock) begin
      pipe_ff[0].depth <= req_depth_mm;
      pipe_ff[0].red   <= req_red;
      pipe_ff[0].green <= req_green;
      pipe_ff[0].blue  <= req_blue;
      for (int i = 1; i < STAGES; i++) begin
         pipe_ff[i] <= pipe_ff[i-1];
      end
      negx_ff <= negx_in;
      negy_ff <= negy_in;
      adx_ff  <= adx_in;
      ady_ff  <= ady_in;
   end

   // stages 2 to 5
   bpj_axis #(.INV_FOCAL_FRAC_BITS(INV_FOCAL_FRAC_BITS)) u_axis_x (
      .clock      (clock),
      .depth      (pipe_ff[0].depth),
      .offset_mag (adx_ff),
      .offset_neg (negx_ff),
      .inv_focal  (cfg.inv_focal_x),
      .coord      (coordx),
      .mag_sq     (sqx)
   );

   bpj_axis #(.INV_FOCAL_FRAC_BITS(INV_FOCAL_FRAC_BITS)) u_axis_y (
      .clock      (clock),
      .depth      (pipe_ff[0].depth),
      .offset_mag (ady_ff),
      .offset_neg (negy_ff),
      .inv_focal  (cfg.inv_focal_y),
      .coord      (coordy),
      .mag_sq     (sqy)
   );

   // stage 5 depth square, stage 6 sum, stage 7 range test
   always_ff @(posedge clock) begin
      dsq_ff  <= pipe_ff[3].depth * pipe_ff[3].depth;
      dist_ff <= bpj_pkg::DIST_W'(dsq_ff) + bpj_pkg::DIST_W'(sqx)
               + bpj_pkg::DIST_W'(sqy);
      left_ff <= coordx;
      up_ff   <= coordy;
   end

   assign in_range = (dist_ff >= bpj_pkg::MIN_RANGE_SQ)
                  && (dist_ff <= bpj_pkg::DIST_W'(cfg.range_sq));

   always_ff @(posedge clock) begin
      rsp_pix_ff  <= pipe_ff[STAGES-1];
      rsp_left_ff <= left_ff;
      rsp_up_ff   <= up_ff;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_forward = rsp_pix_ff.depth;
   assign rsp_pos_left    = rsp_left_ff;
   assign rsp_pos_up      = rsp_up_ff;
   assign rsp_out_red     = rsp_pix_ff.red;
   assign rsp_out_green   = rsp_pix_ff.green;
   assign rsp_out_blue    = rsp_pix_ff.blue;

endmodule

// ===== hdl/bpj_checker.sv =====
// Port-level checker for the back-projection block and its bind.
`include "depth_pixel_backprojection_macros.svh"

module bpj_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic [bpj_pkg::DEPTH_W-1:0]         req_depth_mm,
   input logic [bpj_pkg::COLOR_W-1:0]         req_red,
   input logic [bpj_pkg::COLOR_W-1:0]         req_green,
   input logic [bpj_pkg::COLOR_W-1:0]         req_blue,
   input logic                                rsp_valid,
   input logic [bpj_pkg::DEPTH_W-1:0]         rsp_pos_forward,
   input logic signed [bpj_pkg::COORD_W-1:0]  rsp_pos_left,
   input logic signed [bpj_pkg::COORD_W-1:0]  rsp_pos_up,
   input logic [bpj_pkg::COLOR_W-1:0]         rsp_out_red,
   input logic [bpj_pkg::COLOR_W-1:0]         rsp_out_green,
   input logic [bpj_pkg::COLOR_W-1:0]         rsp_out_blue
);

   localparam int LATENCY = 7;

   `BPJ_ASSERT(a_rsp_has_source, clock, reset, rsp_valid |-> $past(start && !busy, LATENCY), "result without a transaction seven cycles earlier")
   `BPJ_ASSERT(a_rsp_passthrough, clock, reset, rsp_valid |-> (rsp_pos_forward == $past(req_depth_mm, LATENCY) && rsp_out_red == $past(req_red, LATENCY) && rsp_out_green == $past(req_green, LATENCY) && rsp_out_blue == $past(req_blue, LATENCY)), "depth or color not passed through")
   `BPJ_ASSERT(a_rsp_nonzero_depth, clock, reset, rsp_valid |-> (rsp_pos_forward != '0), "point emitted for zero depth")
   `BPJ_ASSERT(a_rsp_not_saturated, clock, reset, rsp_valid |-> (rsp_pos_left != bpj_pkg::NEG_LIMIT && rsp_pos_left != bpj_pkg::POS_LIMIT && rsp_pos_up != bpj_pkg::NEG_LIMIT && rsp_pos_up != bpj_pkg::POS_LIMIT), "saturated point emitted")
   `BPJ_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "result right after reset")

endmodule

bind depth_pixel_backprojection bpj_checker u_bpj_checker (.*);

// ===== tb/depth_pixel_backprojection_tb.sv =====
// Self-checking testbench for the depth pixel back-projection block.
module depth_pixel_backprojection_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIPE_LATENCY = 7;
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_LIMIT  = 200;
   localparam int COORD_BITS   = bpj_pkg::COORD_BITS_DEF;
   localparam int FRAC_BITS    = bpj_pkg::INV_FOCAL_FRAC_BITS_DEF;
   localparam logic [bpj_pkg::PIX_W-1:0] COORD_MASK =
      bpj_pkg::PIX_W'((1 << COORD_BITS) - 1);
   localparam longint unsigned COORD_POS_MAX = 64'd1048575;
   localparam longint unsigned COORD_NEG_MAX = 64'd1048576;
   localparam longint unsigned NEAR_LIMIT_MM = 64'd1500;
   localparam logic [bpj_pkg::CSR_IDX_W-1:0] CSR_INDEX_UNMAPPED = 3'd7;

   typedef struct {
      logic [bpj_pkg::DEPTH_W-1:0] depth;
      logic [bpj_pkg::COLOR_W-1:0] red;
      logic [bpj_pkg::COLOR_W-1:0] green;
      logic [bpj_pkg::COLOR_W-1:0] blue;
      logic [bpj_pkg::PIX_W-1:0]   column;
      logic [bpj_pkg::PIX_W-1:0]   row;
   } depth_pixel_type;

   typedef struct {
      logic [bpj_pkg::DEPTH_W-1:0]        forward;
      logic signed [bpj_pkg::COORD_W-1:0] left;
      logic signed [bpj_pkg::COORD_W-1:0] up;
      logic [bpj_pkg::COLOR_W-1:0]        red;
      logic [bpj_pkg::COLOR_W-1:0]        green;
      logic [bpj_pkg::COLOR_W-1:0]        blue;
   } point_type;

   typedef struct {
      logic [bpj_pkg::SIZE_W-1:0]  image_width;
      logic [bpj_pkg::SIZE_W-1:0]  image_height;
      logic [bpj_pkg::SIZE_W-1:0]  row_first;
      logic [bpj_pkg::SIZE_W-1:0]  row_end;
      logic [bpj_pkg::INV_W-1:0]   inv_focal_x;
      logic [bpj_pkg::INV_W-1:0]   inv_focal_y;
      logic [bpj_pkg::RANGE_W-1:0] range_max;
   } camera_cfg_type;

   logic clock;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [bpj_pkg::DEPTH_W-1:0] req_depth_mm = '0;
   logic [bpj_pkg::COLOR_W-1:0] req_red = '0;
   logic [bpj_pkg::COLOR_W-1:0] req_green = '0;
   logic [bpj_pkg::COLOR_W-1:0] req_blue = '0;
   logic [bpj_pkg::PIX_W-1:0]   req_column = '0;
   logic [bpj_pkg::PIX_W-1:0]   req_row = '0;
   logic rsp_valid;
   logic [bpj_pkg::DEPTH_W-1:0] rsp_pos_forward;
   logic signed [bpj_pkg::COORD_W-1:0] rsp_pos_left;
   logic signed [bpj_pkg::COORD_W-1:0] rsp_pos_up;
   logic [bpj_pkg::COLOR_W-1:0] rsp_out_red;
   logic [bpj_pkg::COLOR_W-1:0] rsp_out_green;
   logic [bpj_pkg::COLOR_W-1:0] rsp_out_blue;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [bpj_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [bpj_pkg::CSR_DATA_W-1:0] csr_data = '0;

   camera_cfg_type cam;
   point_type expected_points[$];
   int failures = 0;
   int pixels_sent = 0;
   int points_checked = 0;
   int settings_used = 1;
   int burst_left = 0;
   int stall_cycles_ff = 0;

   depth_pixel_backprojection uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_depth_mm(req_depth_mm),
      .req_red(req_red),
      .req_green(req_green),
      .req_blue(req_blue),
      .req_column(req_column),
      .req_row(req_row),
      .rsp_valid(rsp_valid),
      .rsp_pos_forward(rsp_pos_forward),
      .rsp_pos_left(rsp_pos_left),
      .rsp_pos_up(rsp_pos_up),
      .rsp_out_red(rsp_out_red),
      .rsp_out_green(rsp_out_green),
      .rsp_out_blue(rsp_out_blue),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // One axis: rounded magnitude of depth * |2*coord - size| * inv / 2^(frac+1), saturated.
   function automatic logic [bpj_pkg::COORD_W-1:0] back_project_axis(
      input logic [bpj_pkg::DEPTH_W-1:0] depth, input logic [bpj_pkg::PIX_W-1:0] coord,
      input logic [bpj_pkg::SIZE_W-1:0] size, input logic [bpj_pkg::INV_W-1:0] inv,
      output longint unsigned mag);
      longint offset2;
      longint unsigned prod;
      longint unsigned rounded;
      bit negative;
      offset2 = 2 * longint'(coord & COORD_MASK) - longint'(size);
      negative = offset2 > 0;
      prod = longint'(depth) * (negative ? offset2 : -offset2) * longint'(inv);
      rounded = (prod + (64'd1 << FRAC_BITS)) >> (FRAC_BITS + 1);
      if (negative) begin
         if (rounded > COORD_NEG_MAX) rounded = COORD_NEG_MAX;
         mag = rounded;
         return bpj_pkg::COORD_W'(64'd0 - rounded);
      end
      if (rounded > COORD_POS_MAX) rounded = COORD_POS_MAX;
      mag = rounded;
      return bpj_pkg::COORD_W'(rounded);
   endfunction

   function automatic bit predict_point(input depth_pixel_type px, output point_type pt);
      longint unsigned mag_left;
      longint unsigned mag_up;
      longint unsigned dist_sq;
      longint unsigned far_sq;
      logic [bpj_pkg::PIX_W-1:0] row;
      row = px.row & COORD_MASK;
      if (row < cam.row_first || row >= cam.row_end) return 1'b0;
      pt.left = back_project_axis(px.depth, px.column, cam.image_width, cam.inv_focal_x,
                                  mag_left);
      pt.up = back_project_axis(px.depth, row, cam.image_height, cam.inv_focal_y, mag_up);
      dist_sq = longint'(px.depth) * longint'(px.depth) + mag_left * mag_left + mag_up * mag_up;
      far_sq = longint'(cam.range_max) * longint'(cam.range_max);
      if (dist_sq < NEAR_LIMIT_MM * NEAR_LIMIT_MM || dist_sq > far_sq) return 1'b0;
      pt.forward = px.depth;
      pt.red = px.red;
      pt.green = px.green;
      pt.blue = px.blue;
      return 1'b1;
   endfunction

   function automatic depth_pixel_type make_pixel(input int unsigned depth,
      input int unsigned red, input int unsigned green, input int unsigned blue,
      input int unsigned column, input int unsigned row);
      depth_pixel_type px;
      px.depth = bpj_pkg::DEPTH_W'(depth);
      px.red = bpj_pkg::COLOR_W'(red);
      px.green = bpj_pkg::COLOR_W'(green);
      px.blue = bpj_pkg::COLOR_W'(blue);
      px.column = bpj_pkg::PIX_W'(column);
      px.row = bpj_pkg::PIX_W'(row);
      return px;
   endfunction

   // Mostly pixels inside the image, the row window and the range; some pure noise.
   function automatic depth_pixel_type random_pixel();
      depth_pixel_type px;
      int unsigned col_top;
      int unsigned row_top;
      int unsigned depth_top;
      px.red = bpj_pkg::COLOR_W'($urandom);
      px.green = bpj_pkg::COLOR_W'($urandom);
      px.blue = bpj_pkg::COLOR_W'($urandom);
      if ($urandom_range(0, 9) == 0) begin
         px.depth = bpj_pkg::DEPTH_W'($urandom);
         px.column = bpj_pkg::PIX_W'($urandom);
         px.row = bpj_pkg::PIX_W'($urandom);
         return px;
      end
      col_top = (cam.image_width == 0) ? 1 : (cam.image_width > 4096 ? 4096 : cam.image_width);
      px.column = bpj_pkg::PIX_W'($urandom_range(0, col_top - 1));
      if (cam.row_end > cam.row_first && cam.row_first < 4096) begin
         row_top = (cam.row_end > 4096) ? 4096 : cam.row_end;
         px.row = bpj_pkg::PIX_W'($urandom_range(cam.row_first, row_top - 1));
      end else begin
         px.row = bpj_pkg::PIX_W'($urandom);
      end
      depth_top = (cam.range_max < 1500) ? 1500 : cam.range_max;
      if ($urandom_range(0, 3) == 0) px.depth = bpj_pkg::DEPTH_W'($urandom);
      else px.depth = bpj_pkg::DEPTH_W'($urandom_range(1500, depth_top));
      return px;
   endfunction

   function automatic int next_gap();
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(8, 40);
      return $urandom_range(0, 17);
   endfunction

   task automatic send_pixel(input depth_pixel_type px);
      point_type pt;
      int gap;
      gap = next_gap();
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_depth_mm <= px.depth;
      req_red <= px.red;
      req_green <= px.green;
      req_blue <= px.blue;
      req_column <= px.column;
      req_row <= px.row;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      pixels_sent++;
      if (predict_point(px, pt)) expected_points = {expected_points, pt};
   endtask

   // Lets the pipeline empty, including pixels that produce no point.
   task automatic drain_pipeline();
      int waited;
      @(negedge clock);
      start <= 1'b0;
      waited = 0;
      while (expected_points.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [bpj_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bpj_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      case (idx)
         bpj_pkg::CSR_IMAGE_WIDTH:  cam.image_width = data[bpj_pkg::SIZE_W-1:0];
         bpj_pkg::CSR_IMAGE_HEIGHT: cam.image_height = data[bpj_pkg::SIZE_W-1:0];
         bpj_pkg::CSR_ROW_FIRST:    cam.row_first = data[bpj_pkg::SIZE_W-1:0];
         bpj_pkg::CSR_ROW_END:      cam.row_end = data[bpj_pkg::SIZE_W-1:0];
         bpj_pkg::CSR_INV_FOCAL_X:  cam.inv_focal_x = data[bpj_pkg::INV_W-1:0];
         bpj_pkg::CSR_INV_FOCAL_Y:  cam.inv_focal_y = data[bpj_pkg::INV_W-1:0];
         bpj_pkg::CSR_RANGE_MAX:    cam.range_max = data[bpj_pkg::RANGE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic program_camera(input int unsigned width, input int unsigned height,
      input int unsigned first, input int unsigned last, input int unsigned inv_x,
      input int unsigned inv_y, input int unsigned range_max);
      drain_pipeline();
      write_reg(bpj_pkg::CSR_IMAGE_WIDTH, bpj_pkg::CSR_DATA_W'(width));
      write_reg(bpj_pkg::CSR_IMAGE_HEIGHT, bpj_pkg::CSR_DATA_W'(height));
      write_reg(bpj_pkg::CSR_ROW_FIRST, bpj_pkg::CSR_DATA_W'(first));
      write_reg(bpj_pkg::CSR_ROW_END, bpj_pkg::CSR_DATA_W'(last));
      write_reg(bpj_pkg::CSR_INV_FOCAL_X, bpj_pkg::CSR_DATA_W'(inv_x));
      write_reg(bpj_pkg::CSR_INV_FOCAL_Y, bpj_pkg::CSR_DATA_W'(inv_y));
      write_reg(bpj_pkg::CSR_RANGE_MAX, bpj_pkg::CSR_DATA_W'(range_max));
      settings_used++;
   endtask

   task automatic program_random_camera(input bit any_range);
      int unsigned width;
      int unsigned height;
      int unsigned first;
      width = $urandom_range(1, 4096);
      height = $urandom_range(1, 4096);
      first = $urandom_range(0, height - 1);
      program_camera(width, height, first, $urandom_range(first + 1, 4096),
                     $urandom_range(8388, 167772), $urandom_range(8388, 167772),
                     any_range ? $urandom_range(0, 65535) : $urandom_range(1500, 65535));
   endtask

   // Reset register values: range limits, image edges, row window edge, bit patterns.
   task automatic test_default_range();
      send_pixel(make_pixel(0, 1, 2, 3, 320, 240));
      send_pixel(make_pixel(1499, 10, 20, 30, 320, 240));
      send_pixel(make_pixel(1500, 40, 50, 60, 320, 240));
      send_pixel(make_pixel(50000, 70, 80, 90, 320, 240));
      send_pixel(make_pixel(50001, 1, 1, 1, 320, 240));
      send_pixel(make_pixel(65535, 255, 255, 255, 0, 0));
      send_pixel(make_pixel(2000, 0, 255, 0, 4095, 479));
      send_pixel(make_pixel(2000, 255, 0, 255, 320, 480));
      send_pixel(make_pixel(16'hAAAA, 8'hAA, 8'h55, 8'hAA, 12'h555, 12'h0AA));
      send_pixel(make_pixel(16'h5555, 8'h55, 8'hAA, 8'h55, 12'hAAA, 12'h155));
   endtask

   // Half-way cases round away from zero; zero width and zero inverse focal give left = 0.
   task automatic test_rounding_ties();
      program_camera(0, 1, 0, 4096, 0, 24'h800000, 65535);
      send_pixel(make_pixel(1502, 11, 22, 33, 5, 0));
      send_pixel(make_pixel(1502, 44, 55, 66, 5, 1));
      send_pixel(make_pixel(1501, 77, 88, 99, 5, 0));
   endtask

   task automatic test_saturation();
      program_camera(4096, 480, 0, 4096, 24'hFFFFFF, 33554, 65535);
      send_pixel(make_pixel(1, 5, 6, 7, 0, 240));
      send_pixel(make_pixel(65535, 8, 9, 10, 0, 240));
      drain_pipeline();
      // upper data bits beyond the register width are dropped, leaving width 1
      write_reg(bpj_pkg::CSR_IMAGE_WIDTH, 24'hFFE001);
      send_pixel(make_pixel(65535, 11, 12, 13, 4095, 240));
   endtask

   task automatic test_range_floor();
      program_camera(640, 480, 0, 480, 33554, 33554, 50000);
      write_reg(bpj_pkg::CSR_RANGE_MAX, 24'hFF03E8);
      send_pixel(make_pixel(1500, 1, 2, 3, 320, 240));
      send_pixel(make_pixel(1000, 4, 5, 6, 320, 240));
      drain_pipeline();
      write_reg(bpj_pkg::CSR_RANGE_MAX, 24'd1500);
      send_pixel(make_pixel(1500, 7, 8, 9, 320, 240));
   endtask

   task automatic test_row_window();
      program_camera(640, 480, 300, 200, 33554, 33554, 50000);
      send_pixel(make_pixel(3000, 1, 2, 3, 320, 250));
      drain_pipeline();
      write_reg(bpj_pkg::CSR_ROW_FIRST, 24'd4096);
      write_reg(bpj_pkg::CSR_ROW_END, 24'd4096);
      send_pixel(make_pixel(3000, 4, 5, 6, 320, 4095));
      drain_pipeline();
      write_reg(bpj_pkg::CSR_ROW_FIRST, 24'd0);
      write_reg(CSR_INDEX_UNMAPPED, 24'd0);
      send_pixel(make_pixel(3000, 7, 8, 9, 320, 4095));
   endtask

   task automatic test_random_sweep();
      int count;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               program_camera(640, 480, 0, 480, 33554, 33554, 50000);
               count = 90;
            end
            1: begin
               program_camera(4096, 4096, 0, 4096, 1, 1, 65535);
               count = 90;
            end
            2, 3: begin
               program_random_camera(1'b0);
               count = 80;
            end
            4: begin
               program_camera(1, 1, 0, 4096, 24'hFFFFFF, 24'hFFFFFF, 65535);
               count = 40;
            end
            default: begin
               program_random_camera(1'b1);
               count = 70;
            end
         endcase
         repeat (count) send_pixel(random_pixel());
      end
   endtask

   task automatic compare_field(input string name, input longint expected, input longint actual);
      if (expected != actual) begin
         $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      point_type exp_pt;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_points.size() == 0) begin
            $error("point transaction with no pending prediction");
            failures++;
         end else begin
            exp_pt = expected_points.pop_front();
            points_checked++;
            compare_field("pos_forward", longint'(exp_pt.forward), longint'(rsp_pos_forward));
            compare_field("pos_left", longint'(exp_pt.left), longint'(rsp_pos_left));
            compare_field("pos_up", longint'(exp_pt.up), longint'(rsp_pos_up));
            compare_field("out_red", longint'(exp_pt.red), longint'(rsp_out_red));
            compare_field("out_green", longint'(exp_pt.green), longint'(rsp_out_green));
            compare_field("out_blue", longint'(exp_pt.blue), longint'(rsp_out_blue));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles_ff <= 0;
      end else begin
         stall_cycles_ff <= stall_cycles_ff + 1;
         if (stall_cycles_ff >= STALL_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      cam.image_width = bpj_pkg::IMAGE_WIDTH_RST;
      cam.image_height = bpj_pkg::IMAGE_HEIGHT_RST;
      cam.row_first = bpj_pkg::ROW_FIRST_RST;
      cam.row_end = bpj_pkg::ROW_END_RST;
      cam.inv_focal_x = bpj_pkg::INV_FOCAL_RST;
      cam.inv_focal_y = bpj_pkg::INV_FOCAL_RST;
      cam.range_max = bpj_pkg::RANGE_MAX_RST;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_range();
      test_rounding_ties();
      test_saturation();
      test_range_floor();
      test_row_window();
      test_random_sweep();

      drain_pipeline();
      if (expected_points.size() != 0) begin
         $error("%0d predicted points never appeared", expected_points.size());
         failures += expected_points.size();
      end
      $display("Sent %0d depth pixels under %0d camera register settings,", pixels_sent,
               settings_used);
      $display("checked %0d emitted points field by field.", points_checked);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
